FILE: hw/rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Types, codes, widths and value conversion helpers for the positional list
// engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  // List geometry
  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1);

  // Fixed item field widths
  localparam int unsigned OP_W     = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FOUND_W  = 4;
  localparam int unsigned ECOUNT_W = 5;

  // Width used when comparing a request position against the count
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [VALUE_WIDTH-1:0] entry_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_READ   = 3'd2,
    OP_LOCATE = 3'd3,
    OP_CLEAR  = 3'd4
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_GET_RD,
    S_GET_DATA,
    S_LOC_RD,
    S_LOC_CMP,
    S_RESP
  } state_e;

  // Request value -> stored entry (sign-extend, then keep the low bits)
  function automatic entry_t to_entry(input logic signed [DATA_W-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[VALUE_WIDTH-1:0];
  endfunction

  // Stored entry -> result field (sign-extend, then keep the low bits)
  function automatic logic [DATA_W-1:0] from_entry(input entry_t e);
    logic signed [63:0] w;
    w = 64'($signed(e));
    return w[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ple_req_if.sv
// ----------------------------------------------------------------------------
// ple_req_if
// Request channel of the positional list engine: valid/ready plus payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface ple_req_if;
  import ple_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink   (input valid, input operation, input position, input value,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ple_rsp_if.sv
// ----------------------------------------------------------------------------
// ple_rsp_if
// Result channel of the positional list engine: valid/ready plus payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface ple_rsp_if;
  import ple_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] read_value;
  logic [FOUND_W-1:0]       found_position;
  logic [ECOUNT_W-1:0]      entry_count;

  modport source (output valid, output status, output read_value,
                  output found_position, output entry_count, input ready);
  modport sink   (input valid, input status, input read_value,
                  input found_position, input entry_count, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed values with insert, delete, read, locate and clear
// at a list position; one status result per request.
// ----------------------------------------------------------------------------
// The list lives in a single-port-per-direction entry memory (one write, one
// registered read per cycle) walked by a small sequencer with one shared
// pointer/compare unit. One request is handled at a time; req_i.ready is high
// only while the sequencer is idle. Insert and delete move one entry per
// read/write pair of the entry memory, locate scans one entry per read of it,
// and clear and rejected requests go straight to the result. A result waits
// in the output register until taken; the next request is accepted as soon as
// that register is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ple_req_if.sink   req_i,
  ple_rsp_if.source rsp_o
);
  import ple_pkg::*;

  // Sequencer and datapath registers
  state_e  state_q, state_d;
  cnt_t    count_q, count_d;
  cnt_t    ptr_q, ptr_d;
  cnt_t    pos_q, pos_d;
  entry_t  val_q, val_d;
  status_e res_status_q, res_status_d;
  logic [DATA_W-1:0] res_value_q, res_value_d;
  cnt_t    res_found_q, res_found_d;

  // Output register
  logic                rsp_valid_q, rsp_valid_d;
  logic [STATUS_W-1:0] rsp_status_q, rsp_status_d;
  logic [DATA_W-1:0]   rsp_value_q, rsp_value_d;
  logic [FOUND_W-1:0]  rsp_found_q, rsp_found_d;
  logic [ECOUNT_W-1:0] rsp_count_q, rsp_count_d;

  // Entry memory
  entry_t           entry_mem [CAPACITY];
  entry_t           rd_data_q;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  entry_t           mem_wdata;

  // Shared pointer unit
  cnt_t ptr_inc, ptr_dec;
  assign ptr_inc = ptr_q + 1'b1;
  assign ptr_dec = ptr_q - 1'b1;

  logic             req_fire;
  logic [CMP_W-1:0] req_pos_ext, count_ext;
  assign req_fire    = req_i.valid && req_i.ready;
  assign req_pos_ext = CMP_W'(req_i.position);
  assign count_ext   = CMP_W'(count_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= entry_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      ptr_q        <= '0;
      pos_q        <= '0;
      val_q        <= '0;
      res_status_q <= ST_OK;
      res_value_q  <= '0;
      res_found_q  <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_status_q <= '0;
      rsp_value_q  <= '0;
      rsp_found_q  <= '0;
      rsp_count_q  <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      ptr_q        <= ptr_d;
      pos_q        <= pos_d;
      val_q        <= val_d;
      res_status_q <= res_status_d;
      res_value_q  <= res_value_d;
      res_found_q  <= res_found_d;
      rsp_valid_q  <= rsp_valid_d;
      rsp_status_q <= rsp_status_d;
      rsp_value_q  <= rsp_value_d;
      rsp_found_q  <= rsp_found_d;
      rsp_count_q  <= rsp_count_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    pos_d        = pos_q;
    val_d        = val_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    res_found_d  = res_found_q;
    rsp_status_d = rsp_status_q;
    rsp_value_d  = rsp_value_q;
    rsp_found_d  = rsp_found_q;
    rsp_count_d  = rsp_count_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = ptr_q[IDX_W-1:0];
    mem_raddr    = ptr_q[IDX_W-1:0];
    mem_wdata    = rd_data_q;
    req_i.ready  = 1'b0;

    case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_fire) begin
          val_d        = to_entry(req_i.value);
          pos_d        = CNT_W'(req_i.position);
          res_value_d  = '0;
          res_found_d  = '0;
          res_status_d = ST_OK;
          state_d      = S_RESP;
          case (opcode_e'(req_i.operation))
            OP_INSERT: begin
              if (req_pos_ext > count_ext) begin
                res_status_d = ST_RANGE;
              end else if (count_q == CNT_W'(CAPACITY)) begin
                res_status_d = ST_FULL;
              end else begin
                ptr_d   = count_q;
                state_d = S_INS_RD;
              end
            end
            OP_DELETE, OP_READ: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
              end else if (req_pos_ext >= count_ext) begin
                res_status_d = ST_RANGE;
              end else begin
                ptr_d   = CNT_W'(req_i.position);
                state_d = (opcode_e'(req_i.operation) == OP_DELETE) ? S_DEL_RD : S_GET_RD;
              end
            end
            OP_LOCATE: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                ptr_d   = '0;
                state_d = S_LOC_RD;
              end
            end
            OP_CLEAR: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                count_d = '0;
              end
            end
            default: begin
              res_status_d = ST_OK;
            end
          endcase
        end
      end

      // Insert: move entries up from the tail, then drop the value in
      S_INS_RD: begin
        if (ptr_q == pos_q) begin
          mem_we    = 1'b1;
          mem_wdata = val_q;
          count_d   = count_q + 1'b1;
          state_d   = S_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_dec[IDX_W-1:0];
          state_d   = S_INS_WR;
        end
      end
      S_INS_WR: begin
        mem_we  = 1'b1;
        ptr_d   = ptr_dec;
        state_d = S_INS_RD;
      end

      // Delete: move entries down to close the gap
      S_DEL_RD: begin
        if (ptr_inc == count_q) begin
          count_d = count_q - 1'b1;
          state_d = S_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_inc[IDX_W-1:0];
          state_d   = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        mem_we  = 1'b1;
        ptr_d   = ptr_inc;
        state_d = S_DEL_RD;
      end

      S_GET_RD: begin
        mem_re  = 1'b1;
        state_d = S_GET_DATA;
      end
      S_GET_DATA: begin
        res_value_d = from_entry(rd_data_q);
        state_d     = S_RESP;
      end

      // Locate: scan from the head, stop at the first match
      S_LOC_RD: begin
        mem_re  = 1'b1;
        state_d = S_LOC_CMP;
      end
      S_LOC_CMP: begin
        if (rd_data_q == val_q) begin
          res_status_d = ST_OK;
          res_found_d  = ptr_q;
          state_d      = S_RESP;
        end else if (ptr_inc == count_q) begin
          res_status_d = ST_NOTFOUND;
          state_d      = S_RESP;
        end else begin
          ptr_d   = ptr_inc;
          state_d = S_LOC_RD;
        end
      end

      S_RESP: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = res_status_q;
          rsp_value_d  = res_value_q;
          rsp_found_d  = FOUND_W'(res_found_q);
          rsp_count_d  = ECOUNT_W'(count_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.read_value     = rsp_value_q;
  assign rsp_o.found_position = rsp_found_q;
  assign rsp_o.entry_count    = rsp_count_q;

  // An accepted request always leaves the idle state
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> state_q != S_IDLE)
    else $error("sequencer idle right after accepting an item");

  // The count only moves at the end of insert/delete or on a clear
  a_count_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> ($past(state_q) == S_INS_RD || $past(state_q) == S_DEL_RD ||
                           $past(state_q) == S_IDLE))
    else $error("entry count changed outside insert, delete or clear");

  // Shifting during insert stays within the live part of the list
  a_ins_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INS_WR |-> (ptr_q > pos_q) && (ptr_q <= count_q) &&
                            (count_q < CNT_W'(CAPACITY)))
    else $error("insert shift pointer out of range");

  // A new result is only loaded from the response state
  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == S_RESP)
    else $error("result presented without passing the response state");

endmodule

`default_nettype wire

FILE: tb/ple_tb_pkg.sv
// ----------------------------------------------------------------------------
// ple_tb_pkg
// Shadow copy of the positional list for the engine testbench. Requests are
// applied to the shadow list as they are accepted; the results that they
// should produce are queued and compared, field by field, with the results
// the engine returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package ple_tb_pkg;
  import ple_pkg::*;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   read_value;
    logic [FOUND_W-1:0]  found_position;
    logic [ECOUNT_W-1:0] entry_count;
  } list_result_t;

  class list_tracker;
    entry_t       shadow[CAPACITY];
    int unsigned  fill;
    list_result_t pending_results[$];
    int unsigned  errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    // request value -> stored width, sign carried through
    function entry_t narrow(logic [DATA_W-1:0] v);
      logic [63:0] w;
      w = {{(64-DATA_W){v[DATA_W-1]}}, v};
      return w[VALUE_WIDTH-1:0];
    endfunction

    function logic [DATA_W-1:0] widen(entry_t e);
      logic [63:0] w;
      w = {{(64-VALUE_WIDTH){e[VALUE_WIDTH-1]}}, e};
      return w[DATA_W-1:0];
    endfunction

    function int unsigned entry_total();
      return fill;
    endfunction

    function logic [DATA_W-1:0] value_at(int unsigned idx);
      return widen(shadow[idx]);
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    function void apply_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                logic [DATA_W-1:0] val);
      list_result_t r;
      entry_t       key;
      int unsigned  p;
      int unsigned  i;
      r.status         = ST_OK;
      r.read_value     = '0;
      r.found_position = '0;
      key = narrow(val);
      p   = 32'(pos);
      case (op)
        OP_INSERT: begin
          // position is checked before fullness
          if (p > fill) begin
            r.status = ST_RANGE;
          end else if (fill >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (i = fill; i > p; i--) shadow[i] = shadow[i-1];
            shadow[p] = key;
            fill++;
          end
        end
        OP_DELETE: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else if (p >= fill) begin
            r.status = ST_RANGE;
          end else begin
            for (i = p; i + 1 < fill; i++) shadow[i] = shadow[i+1];
            fill--;
          end
        end
        OP_READ: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else if (p >= fill) begin
            r.status = ST_RANGE;
          end else begin
            r.read_value = widen(shadow[p]);
          end
        end
        OP_LOCATE: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.status = ST_NOTFOUND;
            for (i = 0; i < fill; i++) begin
              if (shadow[i] == key) begin
                r.status         = ST_OK;
                r.found_position = FOUND_W'(i);
                break;
              end
            end
          end
        end
        OP_CLEAR: begin
          if (fill == 0) r.status = ST_EMPTY;
          else fill = 0;
        end
        default: ;  // unused codes leave the list alone
      endcase
      r.entry_count = ECOUNT_W'(fill);
      pending_results.push_back(r);
    endfunction

    function void compare_result(logic [STATUS_W-1:0] status, logic [DATA_W-1:0] rd,
                                 logic [FOUND_W-1:0] found, logic [ECOUNT_W-1:0] cnt);
      list_result_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result item: status %0d count %0d", status, cnt);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        errors++;
      end
      if (rd !== e.read_value) begin
        $error("read_value: expected %h, got %h", e.read_value, rd);
        errors++;
      end
      if (found !== e.found_position) begin
        $error("found_position: expected %0d, got %0d", e.found_position, found);
        errors++;
      end
      if (cnt !== e.entry_count) begin
        $error("entry_count: expected %0d, got %0d", e.entry_count, cnt);
        errors++;
      end
    endfunction
  endclass

endpackage

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Regression for the positional list engine. A directed pass covers the empty,
// full, out-of-range and not-found cases, then a random pass runs phases that
// grow and shrink the list. Both channels idle at random; every result is
// checked against a shadow list kept in the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import ple_pkg::*;
  import ple_tb_pkg::*;

  localparam logic [OP_W-1:0] OP_RSVD_LO   = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_HI   = 3'd7;
  localparam int unsigned     RANDOM_ITEMS = 600;
  // longest request is a locate that scans all entries of a full list
  localparam int unsigned     DRAIN_CYCLES = 64;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ple_req_if req_if ();
  ple_rsp_if rsp_if ();

  list_tracker list_model;
  int unsigned burst_left = 0;

  positional_list_engine DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(30, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // small values repeat often so locate sees duplicates
  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 32'h8000_0000;
    if (r < 16) return 32'h7fff_ffff;
    if (r < 20) return 32'h0000_0000;
    if (r < 24) return 32'hffff_ffff;
    if (r < 55) return $urandom_range(0, 7);
    return $urandom();
  endfunction

  task automatic issue_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                               input logic [DATA_W-1:0] val);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.position  <= pos;
    req_if.value     <= val;
    do @(posedge clk_i); while (!req_if.ready);
    list_model.apply_request(op, pos, val);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      list_model.compare_result(rsp_if.status, rsp_if.read_value,
                                rsp_if.found_position, rsp_if.entry_count);
  end

  // result side back-pressure
  initial begin
    int unsigned r;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(40, 150)) @(posedge clk_i);
      end else if (r < 60) begin
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else if (r < 92) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned       done_items;
    int unsigned       phase_left;
    int unsigned       n;
    int unsigned       r;
    int unsigned       k;
    bit                grow;
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;

    list_model       = new();
    req_if.valid     = 1'b0;
    req_if.operation = '0;
    req_if.position  = '0;
    req_if.value     = '0;
    done_items       = 0;
    phase_left       = 0;
    grow             = 1'b1;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list
    issue_request(OP_CLEAR,  5'd0, 32'h0);
    issue_request(OP_DELETE, 5'd0, 32'h0);
    issue_request(OP_READ,   5'd0, 32'h0);
    issue_request(OP_LOCATE, 5'd0, 32'h5);
    issue_request(OP_INSERT, 5'd1, 32'h1);
    // single entry, then removal of the only entry
    issue_request(OP_INSERT, 5'd0, 32'h8000_0000);
    issue_request(OP_READ,   5'd0, 32'h0);
    issue_request(OP_DELETE, 5'd0, 32'h0);
    // tail insert, out-of-range read, search hit and miss, unused codes
    issue_request(OP_INSERT, 5'd0, 32'h7fff_ffff);
    issue_request(OP_INSERT, 5'd1, 32'hffff_ffff);
    issue_request(OP_READ,   5'd2, 32'h0);
    issue_request(OP_LOCATE, 5'd0, 32'hffff_ffff);
    issue_request(OP_LOCATE, 5'd0, 32'd12345);
    issue_request(OP_RSVD_LO, 5'd0, 32'h0);
    issue_request(OP_RSVD_HI, 5'd31, 32'hffff_ffff);
    // fill to capacity, then the full-list cases
    for (k = 2; k < CAPACITY; k++) issue_request(OP_INSERT, POS_W'(k % 3), $urandom());
    issue_request(OP_INSERT, 5'd16, 32'h1);
    issue_request(OP_INSERT, 5'd31, 32'h1);
    issue_request(OP_READ,   5'd15, 32'h0);
    issue_request(OP_DELETE, 5'd15, 32'h0);
    issue_request(OP_READ,   5'd15, 32'h0);
    issue_request(OP_CLEAR,  5'd0, 32'h0);

    // random: grow and shrink phases picked at random, with some noise
    while (done_items < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        grow       = 1'($urandom_range(0, 1));
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      n   = list_model.entry_total();
      r   = $urandom_range(0, 99);
      val = pick_value();
      pos = POS_W'($urandom_range(0, 31));
      if (r < 2) begin
        op = OP_CLEAR;
      end else if (r < 5) begin
        op = OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
      end else if (r < 10) begin
        op = OP_W'($urandom_range(OP_INSERT, OP_CLEAR));
      end else begin
        k = $urandom_range(0, 99);
        if (k < (grow ? 55 : 15))      op = OP_INSERT;
        else if (k < (grow ? 70 : 60)) op = OP_DELETE;
        else if (k < (grow ? 85 : 80)) op = OP_READ;
        else                           op = OP_LOCATE;
        if (op == OP_INSERT) pos = POS_W'($urandom_range(0, n));
        else pos = (n > 0) ? POS_W'($urandom_range(0, n - 1)) : '0;
        if (op == OP_LOCATE && n > 0 && $urandom_range(0, 9) < 7)
          val = list_model.value_at($urandom_range(0, n - 1));
      end
      issue_request(op, pos, val);
      if (op <= OP_CLEAR) done_items++;
    end
    req_if.valid <= 1'b0;

    while (list_model.outstanding() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (list_model.errors == 0 && list_model.outstanding() == 0) begin
      $display("positional_list_engine regression: pass");
    end else begin
      $display("positional_list_engine regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("positional_list_engine regression: fail");
    $finish;
  end

endmodule
